### sv/scpu_pkg.sv
package scpu_pkg;

  localparam int unsigned DSTACK_DEPTH = 32;
  localparam int unsigned RSTACK_DEPTH = 32;
  localparam int unsigned DPTR_W = $clog2(DSTACK_DEPTH);
  localparam int unsigned RPTR_W = $clog2(RSTACK_DEPTH);
  localparam int unsigned WORD_W = 16;
  localparam int unsigned PTR_OUT_W = 5;
  localparam int unsigned PTR_MAX_W = 8;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [DPTR_W-1:0] dptr_t;
  typedef logic [RPTR_W-1:0] rptr_t;

  typedef enum logic [1:0] {
    MODE_EXEC = 2'd0,
    MODE_PUSH = 2'd1,
    MODE_POP  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_JUMP  = 2'd0,
    KIND_CJUMP = 2'd1,
    KIND_CALL  = 2'd2,
    KIND_ALU   = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    OP_T     = 4'h0,
    OP_N     = 4'h1,
    OP_ADD   = 4'h2,
    OP_AND   = 4'h3,
    OP_OR    = 4'h4,
    OP_XOR   = 4'h5,
    OP_INV   = 4'h6,
    OP_EQ    = 4'h7,
    OP_LT    = 4'h8,
    OP_RSH   = 4'h9,
    OP_DEC   = 4'hA,
    OP_R     = 4'hB,
    OP_FETCH = 4'hC,
    OP_LSH   = 4'hD,
    OP_DEPTH = 4'hE,
    OP_ULT   = 4'hF
  } alu_op_e;

  typedef enum logic [1:0] {
    DELTA_NONE = 2'd0,
    DELTA_INC  = 2'd1,
    DELTA_DEC2 = 2'd2,
    DELTA_DEC  = 2'd3
  } delta_e;

  localparam int unsigned LIT_BIT     = 15;
  localparam int unsigned RET_BIT     = 12;
  localparam int unsigned T2N_BIT     = 7;
  localparam int unsigned T2R_BIT     = 6;
  localparam int unsigned STORE_BIT   = 5;
  localparam int unsigned TARGET_W    = 13;
  localparam int unsigned LITERAL_W   = 15;

  typedef struct packed {
    word_t                 next_pc;
    word_t                 top;
    word_t                 read_value;
    logic [PTR_OUT_W-1:0]  data_pointer;
    logic [PTR_OUT_W-1:0]  return_pointer;
    logic                  store_enable;
    word_t                 store_addr;
    word_t                 store_data;
    logic                  halted;
  } result_t;

  // Moves a circular stack pointer by a two-bit delta of 0, +1, -2 or -1.
  function automatic logic [PTR_MAX_W-1:0] ptr_move(logic [PTR_MAX_W-1:0] p,
                                                    logic [1:0] code,
                                                    int unsigned depth);
    logic [PTR_MAX_W-1:0] last;
    logic [PTR_MAX_W-1:0] r;
    last = PTR_MAX_W'(depth - 1);
    unique case (delta_e'(code))
      DELTA_NONE: r = p;
      DELTA_INC:  r = (p == last) ? '0 : p + 1'b1;
      DELTA_DEC2: r = (p >= PTR_MAX_W'(2)) ? p - PTR_MAX_W'(2) : p + PTR_MAX_W'(depth - 2);
      DELTA_DEC:  r = (p == '0) ? last : p - 1'b1;
      default:    r = p;
    endcase
    return r;
  endfunction

endpackage

### sv/scpu_alu.sv
module scpu_alu (
  input  scpu_pkg::alu_op_e op_i,
  input  scpu_pkg::word_t   t_i,
  input  scpu_pkg::word_t   n_i,
  input  scpu_pkg::word_t   r_i,
  input  scpu_pkg::word_t   mem_i,
  input  scpu_pkg::dptr_t   dp_i,
  input  scpu_pkg::rptr_t   rp_i,
  output scpu_pkg::word_t   res_o
);
  import scpu_pkg::*;

  word_t depth_word;
  logic  shift_big;

  assign depth_word = (WORD_W'(rp_i) << 8) + WORD_W'(dp_i);
  assign shift_big  = (t_i >= WORD_W'(16));

  always_comb begin
    unique case (op_i)
      OP_T:     res_o = t_i;
      OP_N:     res_o = n_i;
      OP_ADD:   res_o = t_i + n_i;
      OP_AND:   res_o = t_i & n_i;
      OP_OR:    res_o = t_i | n_i;
      OP_XOR:   res_o = t_i ^ n_i;
      OP_INV:   res_o = ~t_i;
      OP_EQ:    res_o = (t_i == n_i) ? '1 : '0;
      OP_LT:    res_o = ($signed(n_i) < $signed(t_i)) ? '1 : '0;
      OP_RSH:   res_o = shift_big ? '0 : (n_i >> t_i[3:0]);
      OP_DEC:   res_o = t_i - 1'b1;
      OP_R:     res_o = r_i;
      OP_FETCH: res_o = mem_i;
      OP_LSH:   res_o = shift_big ? '0 : (n_i << t_i[3:0]);
      OP_DEPTH: res_o = depth_word;
      OP_ULT:   res_o = (n_i < t_i) ? '1 : '0;
      default:  res_o = t_i;
    endcase
  end

endmodule

### sv/scpu_core.sv
module scpu_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [1:0]        mode_i,
  input  scpu_pkg::word_t   insn_i,
  input  scpu_pkg::word_t   fetch_i,
  input  scpu_pkg::word_t   push_i,
  output scpu_pkg::result_t res_o
);
  import scpu_pkg::*;

  word_t top_q, top_d;
  word_t pc_q, pc_d;
  dptr_t dp_q, dp_d;
  rptr_t rp_q, rp_d;
  word_t dstk_q [DSTACK_DEPTH];
  word_t rstk_q [RSTACK_DEPTH];

  logic  dwe, rwe;
  dptr_t dwaddr;
  rptr_t rwaddr;
  word_t dwdata, rwdata;

  word_t n_val, r_val, alu_res, pc_inc, read_val, st_addr, st_data;
  dptr_t dp_inc, dp_dec, dp_alu;
  rptr_t rp_inc, rp_alu;
  logic  st_en, halt;
  logic [PTR_MAX_W-1:0] dp_ext, rp_ext;

  assign n_val  = dstk_q[dp_q];
  assign r_val  = rstk_q[rp_q];
  assign pc_inc = pc_q + 1'b1;
  assign dp_inc = DPTR_W'(ptr_move(PTR_MAX_W'(dp_q), DELTA_INC, DSTACK_DEPTH));
  assign dp_dec = DPTR_W'(ptr_move(PTR_MAX_W'(dp_q), DELTA_DEC, DSTACK_DEPTH));
  assign dp_alu = DPTR_W'(ptr_move(PTR_MAX_W'(dp_q), insn_i[1:0], DSTACK_DEPTH));
  assign rp_inc = RPTR_W'(ptr_move(PTR_MAX_W'(rp_q), DELTA_INC, RSTACK_DEPTH));
  assign rp_alu = RPTR_W'(ptr_move(PTR_MAX_W'(rp_q), insn_i[3:2], RSTACK_DEPTH));

  scpu_alu u_alu (
    .op_i  (alu_op_e'(insn_i[11:8])),
    .t_i   (top_q),
    .n_i   (n_val),
    .r_i   (r_val),
    .mem_i (fetch_i),
    .dp_i  (dp_q),
    .rp_i  (rp_q),
    .res_o (alu_res)
  );

  always_comb begin
    top_d    = top_q;
    pc_d     = pc_q;
    dp_d     = dp_q;
    rp_d     = rp_q;
    dwe      = 1'b0;
    dwaddr   = dp_inc;
    dwdata   = top_q;
    rwe      = 1'b0;
    rwaddr   = rp_inc;
    rwdata   = top_q;
    read_val = '0;
    st_en    = 1'b0;
    st_addr  = '0;
    st_data  = '0;
    halt     = 1'b0;
    unique case (mode_i)
      MODE_EXEC: begin
        pc_d = pc_inc;
        if (insn_i[LIT_BIT]) begin
          dp_d  = dp_inc;
          dwe   = 1'b1;
          top_d = WORD_W'(insn_i[LITERAL_W-1:0]);
        end else begin
          unique case (kind_e'(insn_i[14:13]))
            KIND_JUMP: begin
              pc_d = WORD_W'(insn_i[TARGET_W-1:0]);
            end
            KIND_CJUMP: begin
              top_d = n_val;
              dp_d  = dp_dec;
              if (top_q == '0) begin
                pc_d = WORD_W'(insn_i[TARGET_W-1:0]);
              end
            end
            KIND_CALL: begin
              rp_d   = rp_inc;
              rwe    = 1'b1;
              rwaddr = rp_inc;
              rwdata = {pc_inc[WORD_W-2:0], 1'b0};
              pc_d   = WORD_W'(insn_i[TARGET_W-1:0]);
            end
            KIND_ALU: begin
              if (insn_i[RET_BIT]) begin
                pc_d = {1'b0, r_val[WORD_W-1:1]};
              end
              top_d  = alu_res;
              dp_d   = dp_alu;
              rp_d   = rp_alu;
              dwe    = insn_i[T2N_BIT];
              dwaddr = dp_alu;
              rwe    = insn_i[T2R_BIT];
              rwaddr = rp_alu;
              if (insn_i[STORE_BIT]) begin
                st_en   = 1'b1;
                st_addr = top_q;
                st_data = n_val;
              end
            end
            default: ;
          endcase
        end
        halt = (pc_d == '0);
      end
      MODE_PUSH: begin
        dp_d  = dp_inc;
        dwe   = 1'b1;
        top_d = push_i;
      end
      MODE_POP: begin
        read_val = top_q;
        top_d    = n_val;
        dp_d     = dp_dec;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
      pc_q  <= '1;
      dp_q  <= DPTR_W'(DSTACK_DEPTH - 1);
      rp_q  <= RPTR_W'(RSTACK_DEPTH - 1);
      for (int i = 0; i < DSTACK_DEPTH; i++) begin
        dstk_q[i] <= '0;
      end
      for (int i = 0; i < RSTACK_DEPTH; i++) begin
        rstk_q[i] <= '0;
      end
    end else if (step_i) begin
      top_q <= top_d;
      pc_q  <= pc_d;
      dp_q  <= dp_d;
      rp_q  <= rp_d;
      if (dwe) begin
        dstk_q[dwaddr] <= dwdata;
      end
      if (rwe) begin
        rstk_q[rwaddr] <= rwdata;
      end
    end
  end

  assign dp_ext = PTR_MAX_W'(dp_d);
  assign rp_ext = PTR_MAX_W'(rp_d);

  always_comb begin
    res_o.next_pc        = pc_d;
    res_o.top            = top_d;
    res_o.read_value     = read_val;
    res_o.data_pointer   = dp_ext[PTR_OUT_W-1:0];
    res_o.return_pointer = rp_ext[PTR_OUT_W-1:0];
    res_o.store_enable   = st_en;
    res_o.store_addr     = st_addr;
    res_o.store_data     = st_data;
    res_o.halted         = halt;
  end

endmodule

### sv/stack_cpu_instruction_step.sv
// Two-stack 16-bit Forth processor step unit. Each input beat carries one
// instruction (or a push or pop of a full data-stack word) and yields exactly
// one result beat. A new beat can be accepted every cycle while the outputs do
// not stall. A beat waits in the input register while the execute stage works
// on it, and its result is registered in the result register that drives the
// outputs. The input stalls only while the input register holds a beat and the
// result register holds a result that is not being taken. The single execute
// stage that updates the top register, pointers and both 32-entry stacks sets
// the rate of one beat per cycle while the outputs do not stall. The stacks are
// flip-flop arrays cleared by reset, so the block is ready right after reset.
module stack_cpu_instruction_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] instruction_i,
  input  logic [15:0] fetch_data_i,
  input  logic [15:0] push_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] next_pc_o,
  output logic [15:0] top_o,
  output logic [15:0] read_value_o,
  output logic [4:0]  data_pointer_o,
  output logic [4:0]  return_pointer_o,
  output logic        store_enable_o,
  output logic [15:0] store_addr_o,
  output logic [15:0] store_data_o,
  output logic        halted_o
);
  import scpu_pkg::*;

  logic       in_vld_q, in_vld_d;
  logic       out_vld_q, out_vld_d;
  logic       in_fire, adv;
  logic [1:0] mode_q;
  word_t      insn_q, fetch_q, push_q;
  result_t    res_d, res_q;

  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_vld_d   = in_fire ? 1'b1 : (adv ? 1'b0 : in_vld_q);
  assign out_vld_d  = adv ? 1'b1 : (out_ready_i ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q  <= mode_i;
      insn_q  <= instruction_i;
      fetch_q <= fetch_data_i;
      push_q  <= push_value_i;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  scpu_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (adv),
    .mode_i  (mode_q),
    .insn_i  (insn_q),
    .fetch_i (fetch_q),
    .push_i  (push_q),
    .res_o   (res_d)
  );

  assign out_valid_o      = out_vld_q;
  assign next_pc_o        = res_q.next_pc;
  assign top_o            = res_q.top;
  assign read_value_o     = res_q.read_value;
  assign data_pointer_o   = res_q.data_pointer;
  assign return_pointer_o = res_q.return_pointer;
  assign store_enable_o   = res_q.store_enable;
  assign store_addr_o     = res_q.store_addr;
  assign store_data_o     = res_q.store_data;
  assign halted_o         = res_q.halted;

endmodule

### sv/scpu_checker.sv
module scpu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] next_pc_o,
  input logic [15:0] read_value_o,
  input logic        store_enable_o,
  input logic [15:0] store_addr_o,
  input logic [15:0] store_data_o,
  input logic        halted_o
);

  // A halt is only reported when the program counter lands on zero.
  a_halt_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && halted_o) |-> (next_pc_o == 16'd0))
    else $error("halt reported with nonzero pc");

  // Store fields stay zero unless a store is requested.
  a_store_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !store_enable_o) |-> (store_addr_o == 16'd0 && store_data_o == 16'd0))
    else $error("store fields set without store request");

  // A popped value comes only from a pop beat, which neither halts nor stores.
  a_pop_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && read_value_o != 16'd0) |-> (!halted_o && !store_enable_o))
    else $error("pop beat with halt or store");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(next_pc_o)))
    else $error("stalled result beat changed");

endmodule

bind stack_cpu_instruction_step scpu_checker u_scpu_checker (.*);
